>>> hdl/swdh_pkg.sv
// Shared constants for the SWD host transfer engine: item layout, phase and status codes.
package swdh_pkg;

    // Input item kinds (carried on s_axis_tuser)
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Input tdata layout, lowest bit first
    localparam int IN_AP_BIT   = 0;
    localparam int IN_RNW_BIT  = 1;
    localparam int IN_ADDR_LSB = 2;
    localparam int IN_WD_LSB   = 4;
    localparam int IN_IGN_BIT  = 36;
    localparam int IN_IO_BIT   = 37;
    localparam int IN_W        = 40;

    // Output tdata layout, lowest bit first
    localparam int OUT_CLK_BIT  = 0;
    localparam int OUT_DRV_BIT  = 1;
    localparam int OUT_EN_BIT   = 2;
    localparam int OUT_BUSY_BIT = 3;
    localparam int OUT_DONE_BIT = 4;
    localparam int OUT_ST_LSB   = 5;
    localparam int OUT_RD_LSB   = 8;
    localparam int OUT_W        = 40;

    // Protocol constants
    localparam logic       HDR_START_LVL = 1'b1;
    localparam logic       HDR_STOP_LVL  = 1'b0;
    localparam logic       HDR_PARK_LVL  = 1'b1;
    localparam logic [7:0] DATA_BITS     = 8'd32;
    localparam logic [7:0] HEADER_BITS   = 8'd8;
    localparam logic [7:0] ACK_BITS      = 8'd3;
    localparam logic [7:0] IDLE_RESET    = 8'd8;

    // ACK codes, as received LSB first
    localparam logic [2:0] ACK_OK         = 3'b001;
    localparam logic [2:0] ACK_CODE_WAIT  = 3'b010;
    localparam logic [2:0] ACK_CODE_FAULT = 3'b100;

    // Transfer phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_HDR   = 4'd1;
    localparam logic [3:0] PH_TRN1  = 4'd2;
    localparam logic [3:0] PH_ACK   = 4'd3;
    localparam logic [3:0] PH_TRN2  = 4'd4;
    localparam logic [3:0] PH_WDAT  = 4'd5;
    localparam logic [3:0] PH_RDAT  = 4'd6;
    localparam logic [3:0] PH_TRN3  = 4'd7;
    localparam logic [3:0] PH_TRAIL = 4'd8;

    // Completion status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_PROTO  = 3'd3;
    localparam logic [2:0] ST_PARITY = 3'd4;

endpackage

>>> hdl/swd_host_transfer_engine.sv
// SWD host transfer engine: request header, ACK, data phase and trailing idle per tick item.
//
// Each input item is either a start (latches an AP/DP read or write request while idle) or a
// tick (one SWCLK cycle, carrying the SWDIO level sampled in it). Every item yields exactly one
// result item giving the clock, drive and enable for that cycle plus busy/done/status/read data.
// The block takes one item per clock: the phase step is a few gates between the state registers
// and a one-deep output register, so the only limit is the output register, which accepts a new
// item whenever it is empty or its current item is taken in the same cycle. A result is registered
// and appears in the cycle after its item is accepted. Writes run header, ACK, data, parity, idle.
module swd_host_transfer_engine
(
    input  logic        clk,
    input  logic        rst_n,

    // Trailing idle count register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,

    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: access_port, read_not_write, reg_addr[1:0], write_data[31:0], ack_override,
    //        sampled_io, 2 zero pad bits
    input  logic [39:0] s_axis_tdata,
    // tuser: kind
    input  logic        s_axis_tuser,

    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: clock_pulse, io_drive, io_enable, busy_res, done_res, status[2:0], read_data[31:0]
    output logic [39:0] m_axis_tdata
);

    // Configuration and transfer state
    logic [7:0]  idle_cycles_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  bit_count_reg, bit_count_next;
    logic [31:0] shift_word_reg, shift_word_next;
    logic        parity_reg, parity_next;
    logic [2:0]  ack_reg, ack_next;
    logic        req_ap_reg, req_ap_next;
    logic        req_rnw_reg, req_rnw_next;
    logic        req_a2_reg, req_a2_next;
    logic        req_a3_reg, req_a3_next;
    logic        req_ign_reg, req_ign_next;
    logic [2:0]  status_reg, status_next;

    // Output register
    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    // Decoded input item
    logic        in_acc;
    logic        in_kind;
    logic        in_io;

    // Step results
    logic        o_clk, o_drv, o_en, o_done;
    logic [2:0]  o_status;
    logic [31:0] o_rdata;
    logic        fin;
    logic [7:0]  bc_inc;
    logic [39:0] result;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser;
    assign in_io         = s_axis_tdata[swdh_pkg::IN_IO_BIT];
    assign bc_inc        = bit_count_reg + 8'd1;

    // One phase step per item
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_word_next = shift_word_reg;
        parity_next     = parity_reg;
        ack_next        = ack_reg;
        req_ap_next     = req_ap_reg;
        req_rnw_next    = req_rnw_reg;
        req_a2_next     = req_a2_reg;
        req_a3_next     = req_a3_reg;
        req_ign_next    = req_ign_reg;
        status_next     = status_reg;
        o_clk           = 1'b0;
        o_drv           = 1'b0;
        o_en            = 1'b0;
        o_done          = 1'b0;
        o_status        = swdh_pkg::ST_OK;
        o_rdata         = 32'd0;
        fin             = 1'b0;

        if (in_kind == swdh_pkg::KIND_START)
        begin
            // Start: latch request only when idle
            if (phase_reg == swdh_pkg::PH_IDLE)
            begin
                req_ap_next     = s_axis_tdata[swdh_pkg::IN_AP_BIT];
                req_rnw_next    = s_axis_tdata[swdh_pkg::IN_RNW_BIT];
                req_a2_next     = s_axis_tdata[swdh_pkg::IN_ADDR_LSB];
                req_a3_next     = s_axis_tdata[swdh_pkg::IN_ADDR_LSB + 1];
                req_ign_next    = s_axis_tdata[swdh_pkg::IN_IGN_BIT];
                shift_word_next = s_axis_tdata[swdh_pkg::IN_WD_LSB +: 32];
                phase_next      = swdh_pkg::PH_HDR;
                bit_count_next  = 8'd0;
                parity_next     = 1'b0;
                ack_next        = 3'd0;
                status_next     = swdh_pkg::ST_OK;
            end
        end
        else if (phase_reg != swdh_pkg::PH_IDLE)
        begin
            o_clk = 1'b1;
            unique case (phase_reg)
                swdh_pkg::PH_HDR:
                begin
                    o_en = 1'b1;
                    unique case (bit_count_reg[2:0])
                        3'd0:    o_drv = swdh_pkg::HDR_START_LVL;
                        3'd1:    o_drv = req_ap_reg;
                        3'd2:    o_drv = req_rnw_reg;
                        3'd3:    o_drv = req_a2_reg;
                        3'd4:    o_drv = req_a3_reg;
                        3'd5:    o_drv = req_ap_reg ^ req_rnw_reg ^ req_a2_reg ^ req_a3_reg;
                        3'd6:    o_drv = swdh_pkg::HDR_STOP_LVL;
                        default: o_drv = swdh_pkg::HDR_PARK_LVL;
                    endcase
                    bit_count_next = bc_inc;
                    if (bc_inc >= swdh_pkg::HEADER_BITS)
                    begin
                        phase_next     = swdh_pkg::PH_TRN1;
                        bit_count_next = 8'd0;
                    end
                end
                swdh_pkg::PH_TRN1:
                begin
                    phase_next     = swdh_pkg::PH_ACK;
                    bit_count_next = 8'd0;
                end
                swdh_pkg::PH_ACK:
                begin
                    // ACK arrives LSB first
                    unique case (bit_count_reg[1:0])
                        2'd0:    ack_next = ack_reg | {2'b00, in_io};
                        2'd1:    ack_next = ack_reg | {1'b0, in_io, 1'b0};
                        2'd2:    ack_next = ack_reg | {in_io, 2'b00};
                        default: ack_next = ack_reg;
                    endcase
                    bit_count_next = bc_inc;
                    if (bc_inc >= swdh_pkg::ACK_BITS)
                    begin
                        bit_count_next = 8'd0;
                        if (ack_next == swdh_pkg::ACK_OK || req_ign_reg)
                        begin
                            if (req_rnw_reg)
                            begin
                                phase_next      = swdh_pkg::PH_RDAT;
                                shift_word_next = 32'd0;
                                parity_next     = 1'b0;
                            end
                            else
                            begin
                                phase_next = swdh_pkg::PH_TRN2;
                            end
                        end
                        else
                        begin
                            if (ack_next == swdh_pkg::ACK_CODE_WAIT)
                                status_next = swdh_pkg::ST_WAIT;
                            else if (ack_next == swdh_pkg::ACK_CODE_FAULT)
                                status_next = swdh_pkg::ST_FAULT;
                            else
                                status_next = swdh_pkg::ST_PROTO;
                            fin = 1'b1;
                        end
                    end
                end
                swdh_pkg::PH_TRN2:
                begin
                    phase_next     = swdh_pkg::PH_WDAT;
                    bit_count_next = 8'd0;
                    parity_next    = 1'b0;
                end
                swdh_pkg::PH_WDAT:
                begin
                    // 32 data bits LSB first, then even parity
                    o_en = 1'b1;
                    if (bit_count_reg < swdh_pkg::DATA_BITS)
                    begin
                        o_drv           = shift_word_reg[0];
                        shift_word_next = {1'b0, shift_word_reg[31:1]};
                        parity_next     = parity_reg ^ shift_word_reg[0];
                    end
                    else
                    begin
                        o_drv = parity_reg;
                    end
                    bit_count_next = bc_inc;
                    if (bc_inc > swdh_pkg::DATA_BITS)
                    begin
                        if (idle_cycles_reg == 8'd0)
                            fin = 1'b1;
                        else
                        begin
                            phase_next     = swdh_pkg::PH_TRAIL;
                            bit_count_next = 8'd0;
                        end
                    end
                end
                swdh_pkg::PH_RDAT:
                begin
                    // 32 data bits shifted in from the top, then parity check
                    if (bit_count_reg < swdh_pkg::DATA_BITS)
                    begin
                        shift_word_next = {in_io, shift_word_reg[31:1]};
                        parity_next     = parity_reg ^ in_io;
                    end
                    else if (in_io != parity_reg)
                    begin
                        status_next = swdh_pkg::ST_PARITY;
                    end
                    bit_count_next = bc_inc;
                    if (bc_inc > swdh_pkg::DATA_BITS)
                    begin
                        phase_next     = swdh_pkg::PH_TRN3;
                        bit_count_next = 8'd0;
                    end
                end
                swdh_pkg::PH_TRN3:
                begin
                    if (idle_cycles_reg == 8'd0)
                        fin = 1'b1;
                    else
                    begin
                        phase_next     = swdh_pkg::PH_TRAIL;
                        bit_count_next = 8'd0;
                    end
                end
                swdh_pkg::PH_TRAIL:
                begin
                    o_en           = 1'b1;
                    o_drv          = 1'b0;
                    bit_count_next = bc_inc;
                    if (bc_inc >= idle_cycles_reg)
                        fin = 1'b1;
                end
                default:
                begin
                    // Unused phase codes fall back to idle
                    phase_next     = swdh_pkg::PH_IDLE;
                    bit_count_next = 8'd0;
                    o_clk          = 1'b0;
                end
            endcase

            // Transfer completion
            if (fin)
            begin
                o_done         = 1'b1;
                o_status       = status_next;
                o_rdata        = (req_rnw_reg && status_next == swdh_pkg::ST_OK) ?
                                 shift_word_next : 32'd0;
                phase_next     = swdh_pkg::PH_IDLE;
                bit_count_next = 8'd0;
            end
        end
    end

    // Result packing
    always_comb
    begin
        result                                = '0;
        result[swdh_pkg::OUT_CLK_BIT]         = o_clk;
        result[swdh_pkg::OUT_DRV_BIT]         = o_en & o_drv;
        result[swdh_pkg::OUT_EN_BIT]          = o_en;
        result[swdh_pkg::OUT_BUSY_BIT]        = (phase_next != swdh_pkg::PH_IDLE);
        result[swdh_pkg::OUT_DONE_BIT]        = o_done;
        result[swdh_pkg::OUT_ST_LSB +: 3]     = o_status;
        result[swdh_pkg::OUT_RD_LSB +: 32]    = o_rdata;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles_reg <= swdh_pkg::IDLE_RESET;
        else if (cfg_we)
            idle_cycles_reg <= cfg_data;
    end

    // State registers, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= swdh_pkg::PH_IDLE;
            bit_count_reg  <= 8'd0;
            shift_word_reg <= 32'd0;
            parity_reg     <= 1'b0;
            ack_reg        <= 3'd0;
            req_ap_reg     <= 1'b0;
            req_rnw_reg    <= 1'b0;
            req_a2_reg     <= 1'b0;
            req_a3_reg     <= 1'b0;
            req_ign_reg    <= 1'b0;
            status_reg     <= swdh_pkg::ST_OK;
        end
        else if (in_acc)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_word_reg <= shift_word_next;
            parity_reg     <= parity_next;
            ack_reg        <= ack_next;
            req_ap_reg     <= req_ap_next;
            req_rnw_reg    <= req_rnw_next;
            req_a2_reg     <= req_a2_next;
            req_a3_reg     <= req_a3_next;
            req_ign_reg    <= req_ign_next;
            status_reg     <= status_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (in_acc)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            m_data_reg <= result;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // Phase never leaves the defined range
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= swdh_pkg::PH_TRAIL)
        else $error("phase out of range");

    // A finished transfer reports not busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[swdh_pkg::OUT_DONE_BIT]) |->
        !m_data_reg[swdh_pkg::OUT_BUSY_BIT])
        else $error("done while busy");

    // Nonzero status only with done
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[swdh_pkg::OUT_ST_LSB +: 3] != swdh_pkg::ST_OK) |->
        m_data_reg[swdh_pkg::OUT_DONE_BIT])
        else $error("status without done");

    // A tick taken while idle gives no clock
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_kind == swdh_pkg::KIND_TICK && phase_reg == swdh_pkg::PH_IDLE) |=>
        (!m_data_reg[swdh_pkg::OUT_CLK_BIT] && phase_reg == swdh_pkg::PH_IDLE))
        else $error("clock while idle");
`endif

endmodule
